// File: sv/image_header_size_parser_assert.svh
// Assertion macros for the image header size parser.
// Used by image_header_size_parser.sv; depends on nothing else.
`ifndef IMAGE_HEADER_SIZE_PARSER_ASSERT_SVH
`define IMAGE_HEADER_SIZE_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IHS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/ihs_pkg.sv
// Package for the image header size parser: format codes, JPEG walk phases,
// scan outcome codes and marker constants. No dependencies.
package ihs_pkg;

	// image format codes
	localparam logic [1:0] FMT_NONE = 2'd0;
	localparam logic [1:0] FMT_PNG  = 2'd1;
	localparam logic [1:0] FMT_JPEG = 2'd2;
	localparam logic [1:0] FMT_BMP  = 2'd3;

	// byte counter saturates here
	localparam logic [4:0] POS_LIMIT = 5'd26;

	// first-byte signatures
	localparam logic [7:0] PNG_LEAD  = 8'h89;
	localparam logic [7:0] JPEG_LEAD = 8'hFF;
	localparam logic [7:0] BMP_LEAD  = 8'h42;
	localparam logic [7:0] BMP_SECOND = 8'h4D;

	localparam logic [7:0] PNG_MAGIC [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
		8'h0D, 8'h0A, 8'h1A, 8'h0A};

	// JPEG markers
	localparam logic [7:0] MK_FILL = 8'hFF;
	localparam logic [7:0] MK_SOI  = 8'hD8;
	localparam logic [7:0] MK_EOI  = 8'hD9;
	localparam logic [7:0] MK_SOS  = 8'hDA;
	localparam logic [7:0] MK_SOF_LO = 8'hC0;
	localparam logic [7:0] MK_SOF_HI = 8'hCF;
	localparam logic [7:0] MK_DHT  = 8'hC4;
	localparam logic [7:0] MK_JPG  = 8'hC8;
	localparam logic [7:0] MK_DAC  = 8'hCC;

	// smallest SOF length that carries both dimensions
	localparam logic [15:0] SOF_MIN_LEN = 16'd7;
	// SOF body counter saturates here
	localparam logic [7:0] SOF_IDX_LIMIT = 8'd5;

	typedef enum logic [4:0] {
		PH_SEEK   = 5'b00001,
		PH_FILL   = 5'b00010,
		PH_LEN_HI = 5'b00100,
		PH_LEN_LO = 5'b01000,
		PH_BODY   = 5'b10000
	} jpeg_phase_t;

	typedef enum logic [1:0] {
		SCAN_SEARCH = 2'd0,
		SCAN_FOUND  = 2'd1,
		SCAN_FAILED = 2'd2
	} scan_outcome_t;

	typedef struct packed {
		logic [30:0] image_height;
		logic [30:0] image_width;
		logic [1:0]  image_format;
		logic        size_found;
	} result_t;

	function automatic logic is_sof(input logic [7:0] m);
		return (m >= MK_SOF_LO) && (m <= MK_SOF_HI) &&
			(m != MK_DHT) && (m != MK_JPG) && (m != MK_DAC);
	endfunction

endpackage

// File: sv/image_header_size_parser.sv
// Image header size parser: streams an image file and reports format and size.
// Depends on ihs_pkg and image_header_size_parser_assert.svh.
//
// Usage:
//   Slave channel (s_*): one file byte per transfer in s_tdata, s_tlast set on
//   the final byte of the file. Master channel (m_*): one result transfer per
//   file, issued after the byte marked last; no transfer for other bytes.
//   m_tuser carries size_found and image_format, m_tdata width and height.
//   Formats: PNG (signature, big-endian dims at bytes 16/20), BMP ('BM',
//   little-endian dims at 18/22, absolute height), JPEG (marker walk to the
//   first SOF of length 7 or more). Failed size gives width = height = 0.
// Pipeline: a byte is held in the input register; a last byte's result is
//   loaded into the result register, which drives m_tvalid.
// Throughput: one byte per cycle unless a last byte waits on a full result
//   register, set by the combinational state update between the registers.
// Reset: arst_n clears the input and result valids and all parse state; the
//   block is ready as soon as reset is released. Parse state also returns to
//   its reset value after every last byte, ready for the next file.
// Stall: while a result waits on m_tready, bytes that are not marked last keep
//   flowing; a second last byte waits in the input register and s_tready drops.
`include "image_header_size_parser_assert.svh"

module image_header_size_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [30:0] image_width, [61:31] image_height, [63:62] zero
	output logic [2:0]  m_tuser    // [0] size_found, [2:1] image_format
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       fire_s1;

	// parse state
	logic [4:0]                 pos_q, pos_d;
	logic [1:0]                 fmt_q, fmt_d;
	logic                       sig_ok_q, sig_ok_d;
	ihs_pkg::jpeg_phase_t       phase_q, phase_d;
	logic [15:0]                seg_rem_q, seg_rem_d;
	logic                       seg_frame_q, seg_frame_d;
	logic [7:0]                 hold_q, hold_d;
	logic [31:0]                width_q, width_d;
	logic [31:0]                height_q, height_d;
	ihs_pkg::scan_outcome_t     scan_q, scan_d;

	// result register
	logic                       out_valid_q;
	ihs_pkg::result_t           result_q, result_d;

	logic [15:0] seg_len;
	logic [15:0] seg_rem_dec;
	logic [4:0]  bmp_w_off, bmp_h_off;
	logic [31:0] bmp_abs_h;

	// a byte leaves the input register unless it is last and the result slot is busy
	assign fire_s1  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	assign seg_len     = {hold_q, byte_s1};
	assign seg_rem_dec = seg_rem_q - 16'd1;
	assign bmp_w_off   = pos_q - 5'd18;
	assign bmp_h_off   = pos_q - 5'd22;

	// next-state logic for one byte, plus the result on a last byte
	always_comb begin
		pos_d       = pos_q;
		fmt_d       = fmt_q;
		sig_ok_d    = sig_ok_q;
		phase_d     = phase_q;
		seg_rem_d   = seg_rem_q;
		seg_frame_d = seg_frame_q;
		hold_d      = hold_q;
		width_d     = width_q;
		height_d    = height_q;
		scan_d      = scan_q;
		result_d    = '0;
		bmp_abs_h   = '0;

		if (pos_q == 5'd0) begin
			priority if (byte_s1 == ihs_pkg::PNG_LEAD) fmt_d = ihs_pkg::FMT_PNG;
			else if (byte_s1 == ihs_pkg::JPEG_LEAD)    fmt_d = ihs_pkg::FMT_JPEG;
			else if (byte_s1 == ihs_pkg::BMP_LEAD)     fmt_d = ihs_pkg::FMT_BMP;
			else                                       fmt_d = ihs_pkg::FMT_NONE;
		end else if (fmt_q == ihs_pkg::FMT_PNG) begin
			if (pos_q < 5'd8) begin
				if (byte_s1 != ihs_pkg::PNG_MAGIC[pos_q[2:0]]) sig_ok_d = 1'b0;
			end else if (pos_q >= 5'd16 && pos_q < 5'd20) begin
				width_d = {width_q[23:0], byte_s1};
			end else if (pos_q >= 5'd20 && pos_q < 5'd24) begin
				height_d = {height_q[23:0], byte_s1};
			end
		end else if (fmt_q == ihs_pkg::FMT_BMP) begin
			if (pos_q == 5'd1) begin
				if (byte_s1 != ihs_pkg::BMP_SECOND) sig_ok_d = 1'b0;
			end else if (pos_q >= 5'd18 && pos_q < 5'd22) begin
				width_d[{bmp_w_off[1:0], 3'b000} +: 8] =
					width_q[{bmp_w_off[1:0], 3'b000} +: 8] | byte_s1;
			end else if (pos_q >= 5'd22 && pos_q < 5'd26) begin
				height_d[{bmp_h_off[1:0], 3'b000} +: 8] =
					height_q[{bmp_h_off[1:0], 3'b000} +: 8] | byte_s1;
			end
		end else if (fmt_q == ihs_pkg::FMT_JPEG) begin
			if (pos_q == 5'd1) begin
				if (byte_s1 != ihs_pkg::MK_SOI) sig_ok_d = 1'b0;
			end else if (sig_ok_q && scan_q == ihs_pkg::SCAN_SEARCH) begin
				// marker segment walk
				unique case (phase_q)
					ihs_pkg::PH_SEEK: begin
						if (byte_s1 == ihs_pkg::MK_FILL) phase_d = ihs_pkg::PH_FILL;
					end
					ihs_pkg::PH_FILL: begin
						if (byte_s1 == ihs_pkg::MK_EOI || byte_s1 == ihs_pkg::MK_SOS) begin
							scan_d = ihs_pkg::SCAN_FAILED;
						end else if (byte_s1 != ihs_pkg::MK_FILL) begin
							seg_frame_d = ihs_pkg::is_sof(byte_s1);
							phase_d     = ihs_pkg::PH_LEN_HI;
						end
					end
					ihs_pkg::PH_LEN_HI: begin
						hold_d  = byte_s1;
						phase_d = ihs_pkg::PH_LEN_LO;
					end
					ihs_pkg::PH_LEN_LO: begin
						if (seg_len < 16'd2) begin
							scan_d = ihs_pkg::SCAN_FAILED;
						end else begin
							if (seg_len < ihs_pkg::SOF_MIN_LEN) seg_frame_d = 1'b0;
							seg_rem_d = seg_len - 16'd2;
							hold_d    = '0;
							phase_d   = (seg_len == 16'd2) ? ihs_pkg::PH_SEEK
								: ihs_pkg::PH_BODY;
						end
					end
					ihs_pkg::PH_BODY: begin
						// hold counts SOF body bytes: precision, height x2, width x2
						if (seg_frame_q) begin
							if (hold_q == 8'd1 || hold_q == 8'd2)
								height_d = {16'd0, height_q[7:0], byte_s1};
							else if (hold_q == 8'd3 || hold_q == 8'd4)
								width_d = {16'd0, width_q[7:0], byte_s1};
							if (hold_q < ihs_pkg::SOF_IDX_LIMIT) hold_d = hold_q + 8'd1;
						end
						seg_rem_d = seg_rem_dec;
						if (seg_rem_dec == 16'd0) begin
							if (seg_frame_q)
								scan_d = (width_d != '0 && height_d != '0)
									? ihs_pkg::SCAN_FOUND : ihs_pkg::SCAN_FAILED;
							phase_d = ihs_pkg::PH_SEEK;
						end
					end
					default: phase_d = ihs_pkg::PH_SEEK;
				endcase
			end
		end

		pos_d = (pos_q < ihs_pkg::POS_LIMIT) ? pos_q + 5'd1 : ihs_pkg::POS_LIMIT;

		if (last_s1) begin
			bmp_abs_h = height_d[31] ? (32'd0 - height_d) : height_d;
			if (sig_ok_d) begin
				if (fmt_d == ihs_pkg::FMT_PNG && pos_d >= 5'd8) begin
					result_d.image_format = ihs_pkg::FMT_PNG;
					if (pos_d >= 5'd24 && width_d != '0 && !width_d[31] &&
						height_d != '0 && !height_d[31]) begin
						result_d.size_found   = 1'b1;
						result_d.image_width  = width_d[30:0];
						result_d.image_height = height_d[30:0];
					end
				end else if (fmt_d == ihs_pkg::FMT_JPEG && pos_d >= 5'd2) begin
					result_d.image_format = ihs_pkg::FMT_JPEG;
					if (scan_d == ihs_pkg::SCAN_FOUND) begin
						result_d.size_found   = 1'b1;
						result_d.image_width  = width_d[30:0];
						result_d.image_height = height_d[30:0];
					end
				end else if (fmt_d == ihs_pkg::FMT_BMP && pos_d >= 5'd2) begin
					result_d.image_format = ihs_pkg::FMT_BMP;
					if (pos_d >= 5'd26 && width_d != '0 && !width_d[31] &&
						bmp_abs_h != '0 && !bmp_abs_h[31]) begin
						result_d.size_found   = 1'b1;
						result_d.image_width  = width_d[30:0];
						result_d.image_height = bmp_abs_h[30:0];
					end
				end
			end
			// back to reset values for the next file
			pos_d       = '0;
			fmt_d       = ihs_pkg::FMT_NONE;
			sig_ok_d    = 1'b1;
			phase_d     = ihs_pkg::PH_SEEK;
			seg_rem_d   = '0;
			seg_frame_d = 1'b0;
			hold_d      = '0;
			width_d     = '0;
			height_d    = '0;
			scan_d      = ihs_pkg::SCAN_SEARCH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			fmt_q       <= ihs_pkg::FMT_NONE;
			sig_ok_q    <= 1'b1;
			phase_q     <= ihs_pkg::PH_SEEK;
			seg_rem_q   <= '0;
			seg_frame_q <= 1'b0;
			hold_q      <= '0;
			width_q     <= '0;
			height_q    <= '0;
			scan_q      <= ihs_pkg::SCAN_SEARCH;
		end else if (fire_s1) begin
			pos_q       <= pos_d;
			fmt_q       <= fmt_d;
			sig_ok_q    <= sig_ok_d;
			phase_q     <= phase_d;
			seg_rem_q   <= seg_rem_d;
			seg_frame_q <= seg_frame_d;
			hold_q      <= hold_d;
			width_q     <= width_d;
			height_q    <= height_d;
			scan_q      <= scan_d;
		end
	end

	// result register: loaded by a last byte, freed by a master transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			result_q <= result_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, result_q.image_height, result_q.image_width};
	assign m_tuser  = {result_q.image_format, result_q.size_found};

	// checks
	`IHS_ASSERT_IMPLY(a_found_has_format, clk, arst_n, m_tvalid && m_tuser[0], m_tuser[2:1] != ihs_pkg::FMT_NONE, "size found without a recognized format")
	`IHS_ASSERT_IMPLY(a_fail_zero_dims, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata[61:0] == '0, "failed result carries nonzero dimensions")
	`IHS_ASSERT_NEXT(a_state_cleared, clk, arst_n, fire_s1 && last_s1, pos_q == '0 && phase_q == ihs_pkg::PH_SEEK && scan_q == ihs_pkg::SCAN_SEARCH && sig_ok_q, "parse state not cleared after last byte")
	`IHS_ASSERT_IMPLY(a_pos_bound, clk, arst_n, valid_s1, pos_q <= ihs_pkg::POS_LIMIT, "byte position beyond saturation limit")

endmodule

// File: tb/tb_image_header_size_parser.sv
`timescale 1ns / 100ps
// Self-checking testbench for image_header_size_parser: streams PNG, BMP and JPEG files
// (directed, then random) and checks every result against a local predictor.
// Depends on ihs_pkg and the image_header_size_parser RTL.

module tb_image_header_size_parser;

	// PNG signature and IHDR chunk head
	localparam logic [7:0] PNG_SIGNATURE [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
		8'h0D, 8'h0A, 8'h1A, 8'h0A};
	localparam logic [7:0] IHDR_HEAD [8] = '{8'h00, 8'h00, 8'h00, 8'h0D,
		8'h49, 8'h48, 8'h44, 8'h52};

	// BMP magic
	localparam logic [7:0] LEAD_B = 8'h42;
	localparam logic [7:0] LEAD_M = 8'h4D;

	// JPEG marker codes
	localparam logic [7:0] TAG_PAD   = 8'hFF;
	localparam logic [7:0] TAG_SOI   = 8'hD8;
	localparam logic [7:0] TAG_EOI   = 8'hD9;
	localparam logic [7:0] TAG_SOS   = 8'hDA;
	localparam logic [7:0] TAG_RST0  = 8'hD0;
	localparam logic [7:0] TAG_APP0  = 8'hE0;
	localparam logic [7:0] TAG_APP1  = 8'hE1;
	localparam logic [7:0] TAG_DQT   = 8'hDB;
	localparam logic [7:0] TAG_DHT   = 8'hC4;
	localparam logic [7:0] TAG_JPG   = 8'hC8;
	localparam logic [7:0] TAG_DAC   = 8'hCC;
	localparam logic [7:0] TAG_SOF0  = 8'hC0;
	localparam logic [7:0] TAG_SOF1  = 8'hC1;
	localparam logic [7:0] TAG_SOF2  = 8'hC2;
	localparam logic [7:0] TAG_SOF15 = 8'hCF;

	localparam logic [4:0]  POS_CAP       = 5'd26;   // byte counter saturation
	localparam logic [15:0] FRAME_MIN_LEN = 16'd7;   // SOF must carry both dims
	localparam logic [7:0]  BODY_IDX_CAP  = 8'd5;    // SOF body index saturation
	localparam int          QUIET_LIMIT   = 4000;    // cycles with no transfer

	typedef enum logic [2:0] {
		WALK_SEEK, WALK_FILL, WALK_LEN_HI, WALK_LEN_LO, WALK_BODY
	} walk_phase_t;

	typedef enum logic [1:0] {
		OUT_SEARCH, OUT_FOUND, OUT_FAILED
	} walk_outcome_t;

	typedef enum logic [1:0] {
		RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT
	} rx_mode_t;

	typedef struct packed {
		logic        found;
		logic [1:0]  fmt;
		logic [30:0] width;
		logic [30:0] height;
	} size_report_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
	logic        s_tlast  = 1'b0;    // last_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;            // [30:0] image_width, [61:31] image_height
	logic [2:0]  m_tuser;            // [0] size_found, [2:1] image_format

	image_header_size_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Parse predictor: mirrors the header parse on every accepted byte.
	// ------------------------------------------------------------------
	logic [4:0]     pos_seen;
	logic [1:0]     fmt_guess;
	logic           sig_match;
	walk_phase_t    walk;
	logic [15:0]    seg_left;
	logic           seg_frame;
	logic [7:0]     len_hold;    // length high byte, then SOF body index
	logic [31:0]    w_acc;
	logic [31:0]    h_acc;
	walk_outcome_t  walk_result;

	size_report_t expected_sizes[$];
	int           mismatch_count = 0;

	logic [7:0] file_buf[$];     // file being built for the next send
	int         burst_left = 0;

	task automatic clear_parse();
		pos_seen    = '0;
		fmt_guess   = ihs_pkg::FMT_NONE;
		sig_match   = 1'b1;
		walk        = WALK_SEEK;
		seg_left    = '0;
		seg_frame   = 1'b0;
		len_hold    = '0;
		w_acc       = '0;
		h_acc       = '0;
		walk_result = OUT_SEARCH;
	endtask

	// SOF is C0..CF except DHT (C4), JPG (C8) and DAC (CC)
	function automatic logic is_frame_tag(input logic [7:0] t);
		return (t[7:4] == 4'hC) && !(t[1:0] == 2'b00 && t[3:2] != 2'b00);
	endfunction

	function automatic logic dim_valid(input logic [31:0] v);
		return (v != 32'd0) && !v[31];
	endfunction

	// One byte of the JPEG marker walk.
	task automatic walk_jpeg(input logic [7:0] b);
		logic [15:0] seg_len;
		case (walk)
			WALK_SEEK: if (b == TAG_PAD) walk = WALK_FILL;
			WALK_FILL: begin
				if (b == TAG_EOI || b == TAG_SOS) begin
					walk_result = OUT_FAILED;
				end else if (b != TAG_PAD) begin
					seg_frame = is_frame_tag(b);
					walk      = WALK_LEN_HI;
				end
			end
			WALK_LEN_HI: begin
				len_hold = b;
				walk     = WALK_LEN_LO;
			end
			WALK_LEN_LO: begin
				seg_len = {len_hold, b};
				if (seg_len < 16'd2) begin
					walk_result = OUT_FAILED;
				end else begin
					if (seg_len < FRAME_MIN_LEN) seg_frame = 1'b0;
					seg_left = seg_len - 16'd2;
					len_hold = '0;
					walk     = (seg_left == 16'd0) ? WALK_SEEK : WALK_BODY;
				end
			end
			default: begin
				// SOF body: precision, height hi/lo, width hi/lo
				if (seg_frame) begin
					if (len_hold == 8'd1 || len_hold == 8'd2)
						h_acc = {16'h0, h_acc[7:0], b};
					else if (len_hold == 8'd3 || len_hold == 8'd4)
						w_acc = {16'h0, w_acc[7:0], b};
					if (len_hold < BODY_IDX_CAP) len_hold = len_hold + 8'd1;
				end
				seg_left = seg_left - 16'd1;
				if (seg_left == 16'd0) begin
					if (seg_frame)
						walk_result = (w_acc != 0 && h_acc != 0) ? OUT_FOUND : OUT_FAILED;
					walk = WALK_SEEK;
				end
			end
		endcase
	endtask

	// Update on one accepted byte; on the last byte, queue the expected report.
	task automatic parse_byte(input logic [7:0] b, input logic last);
		logic [4:0]   p;
		logic [31:0]  abs_h;
		size_report_t rep;
		p = pos_seen;
		if (p == 5'd0) begin
			if (b == PNG_SIGNATURE[0])  fmt_guess = ihs_pkg::FMT_PNG;
			else if (b == TAG_PAD)      fmt_guess = ihs_pkg::FMT_JPEG;
			else if (b == LEAD_B)       fmt_guess = ihs_pkg::FMT_BMP;
			else                        fmt_guess = ihs_pkg::FMT_NONE;
		end else if (fmt_guess == ihs_pkg::FMT_PNG) begin
			if (p < 5'd8) begin
				if (b != PNG_SIGNATURE[p[2:0]]) sig_match = 1'b0;
			end else if (p >= 5'd16 && p < 5'd20) begin
				w_acc = {w_acc[23:0], b};
			end else if (p >= 5'd20 && p < 5'd24) begin
				h_acc = {h_acc[23:0], b};
			end
		end else if (fmt_guess == ihs_pkg::FMT_BMP) begin
			if (p == 5'd1) begin
				if (b != LEAD_M) sig_match = 1'b0;
			end else if (p >= 5'd18 && p < 5'd22) begin
				w_acc = w_acc | (32'(b) << (8 * (p - 5'd18)));
			end else if (p >= 5'd22 && p < 5'd26) begin
				h_acc = h_acc | (32'(b) << (8 * (p - 5'd22)));
			end
		end else if (fmt_guess == ihs_pkg::FMT_JPEG) begin
			if (p == 5'd1) begin
				if (b != TAG_SOI) sig_match = 1'b0;
			end else if (sig_match && walk_result == OUT_SEARCH) begin
				walk_jpeg(b);
			end
		end
		pos_seen = (p < POS_CAP) ? p + 5'd1 : POS_CAP;

		if (last) begin
			rep = '0;
			rep.fmt = ihs_pkg::FMT_NONE;
			if (sig_match) begin
				if (fmt_guess == ihs_pkg::FMT_PNG && pos_seen >= 5'd8) begin
					rep.fmt = ihs_pkg::FMT_PNG;
					if (pos_seen >= 5'd24 && dim_valid(w_acc) && dim_valid(h_acc)) begin
						rep.found  = 1'b1;
						rep.width  = w_acc[30:0];
						rep.height = h_acc[30:0];
					end
				end else if (fmt_guess == ihs_pkg::FMT_JPEG && pos_seen >= 5'd2) begin
					rep.fmt = ihs_pkg::FMT_JPEG;
					if (walk_result == OUT_FOUND) begin
						rep.found  = 1'b1;
						rep.width  = w_acc[30:0];
						rep.height = h_acc[30:0];
					end
				end else if (fmt_guess == ihs_pkg::FMT_BMP && pos_seen >= 5'd2) begin
					rep.fmt = ihs_pkg::FMT_BMP;
					// top-down bitmaps store a negative height
					abs_h = h_acc[31] ? (~h_acc + 32'd1) : h_acc;
					if (pos_seen >= POS_CAP && dim_valid(w_acc) && dim_valid(abs_h)) begin
						rep.found  = 1'b1;
						rep.width  = w_acc[30:0];
						rep.height = abs_h[30:0];
					end
				end
			end
			expected_sizes = {expected_sizes, rep};
			clear_parse();
		end
	endtask

	// ------------------------------------------------------------------
	// Byte sender: bursts of random length separated by random gaps.
	// tvalid stays high across a burst; data changes only after a transfer.
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 3);
			// now and then a long run with no gaps at all
			burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(80, 250)
				: $urandom_range(1, 20);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		parse_byte(b, last);
	endtask

	task automatic send_file();
		foreach (file_buf[i]) send_byte(file_buf[i], i == file_buf.size() - 1);
	endtask

	// Sender holds off until every queued report has come back.
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_sizes.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// File builders
	// ------------------------------------------------------------------
	task automatic put_byte(input logic [7:0] b);
		file_buf = {file_buf, b};
	endtask

	task automatic add_tail(input int n);
		repeat (n) put_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic cut_file(input int keep);
		while (file_buf.size() > keep) void'(file_buf.pop_back());
	endtask

	task automatic corrupt(input int idx);
		file_buf[idx] = file_buf[idx] ^ 8'($urandom_range(1, 255));
	endtask

	task automatic build_png(input logic [31:0] w, input logic [31:0] h, input int extra);
		file_buf = {};
		foreach (PNG_SIGNATURE[i]) put_byte(PNG_SIGNATURE[i]);
		foreach (IHDR_HEAD[i]) put_byte(IHDR_HEAD[i]);
		for (int i = 3; i >= 0; i--) put_byte(w[8*i +: 8]);
		for (int i = 3; i >= 0; i--) put_byte(h[8*i +: 8]);
		add_tail(extra);
	endtask

	task automatic build_bmp(input logic [31:0] w, input logic [31:0] h, input int extra);
		file_buf = {};
		put_byte(LEAD_B);
		put_byte(LEAD_M);
		add_tail(16);   // file header and DIB size, not checked
		for (int i = 0; i < 4; i++) put_byte(w[8*i +: 8]);
		for (int i = 0; i < 4; i++) put_byte(h[8*i +: 8]);
		add_tail(extra);
	endtask

	task automatic jpeg_soi();
		file_buf = {};
		put_byte(TAG_PAD);
		put_byte(TAG_SOI);
	endtask

	// stray bytes that are never 0xFF
	task automatic jpeg_junk(input int n);
		repeat (n) put_byte(8'($urandom_range(0, 254)));
	endtask

	task automatic jpeg_marker(input logic [7:0] tag, input int pads);
		put_byte(TAG_PAD);
		repeat (pads) put_byte(TAG_PAD);
		put_byte(tag);
	endtask

	task automatic jpeg_seg(input logic [7:0] tag, input int len, input int pads);
		jpeg_marker(tag, pads);
		put_byte(8'(len >> 8));
		put_byte(8'(len));
		if (len > 2) add_tail(len - 2);
	endtask

	task automatic jpeg_frame(input logic [7:0] tag, input int len,
			input logic [15:0] h, input logic [15:0] w, input int pads);
		jpeg_marker(tag, pads);
		put_byte(8'(len >> 8));
		put_byte(8'(len));
		if (len >= 7) begin
			put_byte(8'd8);
			put_byte(h[15:8]);
			put_byte(h[7:0]);
			put_byte(w[15:8]);
			put_byte(w[7:0]);
			add_tail(len - 7);
		end else if (len > 2) begin
			add_tail(len - 2);
		end
	endtask

	function automatic logic [31:0] pick_dim32();
		case ($urandom_range(0, 7))
			0:       return 32'd0;
			1:       return 32'd1;
			2:       return 32'h7FFF_FFFF;
			3:       return 32'h8000_0000;
			4:       return $urandom;
			5:       return -32'($urandom_range(1, 4096));
			default: return 32'($urandom_range(1, 4096));
		endcase
	endfunction

	function automatic logic [15:0] pick_dim16();
		case ($urandom_range(0, 5))
			0:       return 16'd0;
			1:       return 16'd1;
			2:       return 16'hFFFF;
			3:       return 16'($urandom);
			default: return 16'($urandom_range(1, 2048));
		endcase
	endfunction

	function automatic logic [7:0] pick_frame_tag();
		logic [7:0] t;
		t = 8'($urandom_range(TAG_SOF0, TAG_SOF15));
		return is_frame_tag(t) ? t : TAG_SOF0;
	endfunction

	// any marker that does not end the walk (may well be a SOF)
	function automatic logic [7:0] pick_any_tag();
		logic [7:0] t;
		t = 8'($urandom_range(0, 254));
		return (t == TAG_EOI || t == TAG_SOS) ? TAG_APP0 : t;
	endfunction

	function automatic int pick_seg_len();
		return ($urandom_range(0, 15) == 0) ? $urandom_range(256, 700) : $urandom_range(2, 20);
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_png_headers();
		build_png(32'd1, 32'd1, 0);                     send_file();
		build_png(32'h7FFF_FFFF, 32'h7FFF_FFFF, 3);     send_file();
		build_png(32'd0, 32'd200, 0);                   send_file();
		build_png(32'd300, 32'h8000_0000, 0);           send_file();
		build_png(32'd5, 32'd5, 0); corrupt(3);         send_file();
		build_png(32'd9, 32'd9, 0); cut_file(23);       send_file();  // height cut short
		build_png(32'd9, 32'd9, 0); cut_file(5);        send_file();  // ends inside signature
		build_png(32'd9, 32'd9, 0); cut_file(8);        send_file();  // signature only
		wait_for_drain();
	endtask

	task automatic test_bmp_headers();
		build_bmp(32'd640, -32'sd480, 0);               send_file();  // top-down
		build_bmp(32'd7, 32'h8000_0000, 0);             send_file();  // no positive abs
		build_bmp(32'h7FFF_FFFF, 32'd1, 4);             send_file();
		build_bmp(32'd3, 32'd3, 0); corrupt(1);         send_file();
		build_bmp(32'd3, 32'd3, 0); cut_file(25);       send_file();
		build_bmp(32'd3, 32'd3, 0); cut_file(2);        send_file();
	endtask

	task automatic test_jpeg_walk();
		// junk, fill bytes and an APP segment ahead of a baseline frame
		jpeg_soi(); jpeg_junk(2); jpeg_seg(TAG_APP0, 16, 2);
		jpeg_frame(TAG_SOF0, 17, 16'd480, 16'd640, 0);  send_file();
		// short SOF is skipped, the next one counts
		jpeg_soi(); jpeg_frame(TAG_SOF0, 6, 16'd1, 16'd1, 0);
		jpeg_frame(TAG_SOF2, 11, 16'hFFFF, 16'hFFFF, 1); send_file();
		// C4/C8/CC look like SOF but are not
		jpeg_soi(); jpeg_seg(TAG_DHT, 9, 0); jpeg_seg(TAG_JPG, 2, 0);
		jpeg_seg(TAG_DAC, 4, 0); jpeg_frame(TAG_SOF15, 8, 16'd1, 16'd1, 0); send_file();
		jpeg_soi(); jpeg_marker(TAG_EOI, 0); add_tail(3);                    send_file();
		jpeg_soi(); jpeg_seg(TAG_DQT, 3, 0); jpeg_marker(TAG_SOS, 0); add_tail(2);
		send_file();
		jpeg_soi(); jpeg_seg(TAG_APP1, 0, 0); add_tail(2);                   send_file();
		jpeg_soi(); jpeg_seg(TAG_APP1, 1, 0);                                send_file();
		jpeg_soi(); jpeg_frame(TAG_SOF0, 11, 16'd100, 16'd0, 0);             send_file();
		jpeg_soi(); jpeg_frame(TAG_SOF0, 17, 16'd10, 16'd10, 0);
		cut_file(file_buf.size() - 3);                                       send_file();
		jpeg_soi(); file_buf[1] = TAG_EOI; jpeg_frame(TAG_SOF0, 11, 16'd4, 16'd4, 0);
		send_file();
		// RST and SOI inside the stream still carry a length here
		jpeg_soi(); jpeg_seg(TAG_RST0, 2, 0); jpeg_seg(TAG_SOI, 4, 0);
		jpeg_frame(TAG_SOF1, 7, 16'd33, 16'd77, 0);                          send_file();
		jpeg_soi();                                                          send_file();
		jpeg_soi(); cut_file(1);                                             send_file();
	endtask

	task automatic test_odd_files();
		file_buf = {8'h00, 8'h12, 8'h34};  send_file();
		file_buf = {LEAD_B};               send_file();
	endtask

	task automatic random_png();
		build_png(pick_dim32(), pick_dim32(), $urandom_range(0, 6));
		if ($urandom_range(0, 6) == 0) corrupt($urandom_range(1, 7));
		if ($urandom_range(0, 6) == 0) cut_file($urandom_range(1, file_buf.size()));
	endtask

	task automatic random_bmp();
		build_bmp(pick_dim32(), pick_dim32(), $urandom_range(0, 6));
		if ($urandom_range(0, 9) == 0) corrupt(1);
		if ($urandom_range(0, 6) == 0) cut_file($urandom_range(1, file_buf.size()));
	endtask

	task automatic random_jpeg();
		int nseg;
		int pick;
		jpeg_soi();
		if ($urandom_range(0, 9) == 0) file_buf[1] = 8'($urandom_range(0, 255));
		nseg = $urandom_range(0, 4);
		repeat (nseg) begin
			case ($urandom_range(0, 5))
				0: jpeg_junk($urandom_range(1, 3));
				1: jpeg_frame(pick_frame_tag(), $urandom_range(2, 6), pick_dim16(),
					pick_dim16(), 0);
				2: jpeg_seg($urandom_range(0, 1) ? TAG_DHT : TAG_DAC, pick_seg_len(), 0);
				default: jpeg_seg(pick_any_tag(), pick_seg_len(), $urandom_range(0, 2));
			endcase
		end
		pick = $urandom_range(0, 19);
		if (pick < 15) begin
			jpeg_frame(pick_frame_tag(), $urandom_range(7, 17), pick_dim16(), pick_dim16(),
				$urandom_range(0, 1));
		end else if (pick < 17) begin
			jpeg_marker((pick == 15) ? TAG_EOI : TAG_SOS, 0);
		end else if (pick == 17) begin
			jpeg_seg(pick_any_tag(), $urandom_range(0, 1), 0);  // bad length
		end
		add_tail($urandom_range(0, 4));
		if ($urandom_range(0, 7) == 0) cut_file($urandom_range(1, file_buf.size()));
	endtask

	task automatic random_noise();
		file_buf = {};
		add_tail($urandom_range(1, 40));
	endtask

	// random files on top of the directed ones, about 100 bytes
	task automatic test_random_files();
		int bytes_sent;
		int kind;
		bytes_sent = 0;
		while (bytes_sent < 100) begin
			kind = $urandom_range(0, 19);
			if (kind < 6)       random_png();
			else if (kind < 11) random_bmp();
			else if (kind < 18) random_jpeg();
			else                random_noise();
			bytes_sent += file_buf.size();
			send_file();
			if ($urandom_range(0, 24) == 0) wait_for_drain();
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: stall pattern, checker, watchdog
	// ------------------------------------------------------------------
	rx_mode_t rx_mode      = RX_OPEN;
	int       rx_phase_left = 0;

	always @(posedge clk) begin
		if (rx_phase_left == 0) begin
			rx_mode       <= rx_mode_t'($urandom_range(0, 3));
			rx_phase_left <= $urandom_range(16, 160);
		end else begin
			rx_phase_left <= rx_phase_left - 1;
		end
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
			default:   m_tready <= rx_phase_left[2];   // on and off in alternating runs, from bit 2 of the phase count
		endcase
	end

	// Compare each result transfer with the oldest pending report.
	always @(posedge clk) begin : check_reports
		size_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_sizes.size() == 0) begin
				$error("result transfer with no file pending");
				mismatch_count++;
			end else begin
				want = expected_sizes.pop_front();
				if (m_tuser[0] !== want.found) begin
					$error("size_found: expected %0d, got %0d", want.found, m_tuser[0]);
					mismatch_count++;
				end
				if (m_tuser[2:1] !== want.fmt) begin
					$error("image_format: expected %0d, got %0d", want.fmt, m_tuser[2:1]);
					mismatch_count++;
				end
				if (m_tdata[30:0] !== want.width) begin
					$error("image_width: expected %0d, got %0d", want.width, m_tdata[30:0]);
					mismatch_count++;
				end
				if (m_tdata[61:31] !== want.height) begin
					$error("image_height: expected %0d, got %0d", want.height, m_tdata[61:31]);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: too long without a transfer on either side ends the run.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		clear_parse();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_png_headers();
		test_bmp_headers();
		test_jpeg_walk();
		test_odd_files();
		test_random_files();

		// let the last reports come out, then wait idle for any stragglers
		wait_for_drain();
		repeat (8) @(posedge clk);

		if (mismatch_count == 0 && expected_sizes.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/ihs_pkg.sv
sv/image_header_size_parser.sv
tb/tb_image_header_size_parser.sv
